>>> sv/fqsr_pkg.sv
// Package for the FIFO queue with search and reverse.
// Holds operation and status codes, the sequencer state type and the result record.
// No dependencies; the other files that use it refer to it by scoped names.
package fqsr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int WORD_WIDTH_DEFAULT = 32;

  // Operation codes carried in the op field.
  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_DEQUEUE = 3'd1;
  localparam logic [2:0] OP_COUNT   = 3'd2;
  localparam logic [2:0] OP_SEARCH  = 3'd3;
  localparam logic [2:0] OP_REVERSE = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Sequencer states of the controller.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } fqsr_state_t;

  // One result transaction as it leaves the controller.
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  found_position;
    logic [4:0]  occupancy;
    logic [31:0] removed_value;
  } fqsr_result_t;

endpackage

>>> sv/fifo_queue_with_search_reverse_unit.sv
// Top level of the FIFO queue with search and reverse.
// Instantiates the controller and the entry RAM and holds the output register.
// Depends on fqsr_pkg, fqsr_ram and fqsr_ctrl.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   in      | in_valid, in_stall | op, value
//   out     | out_valid, out_stall | status, found_position, occupancy, removed_value
//
// Enqueue, count, reverse and every empty or full case go from idle straight to the emit
// state; a dequeue passes through the read state first for the registered RAM read.
// Search stays in the scan state until the match, or through the whole occupancy
// when nothing matches: the RAM read port yields one entry per cycle.
// One transaction is in work at a time; a stalled output holds the next result back.
// Reset clears pointers, count, direction flag and sequencer; the RAM is not cleared.
module fifo_queue_with_search_reverse_unit #(
  parameter int DEPTH      = fqsr_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = fqsr_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [4:0]         found_position,
  output logic [4:0]         occupancy,
  output logic signed [31:0] removed_value
);

  localparam int IW = $clog2(DEPTH);

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [WORD_WIDTH-1:0]  wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [WORD_WIDTH-1:0]  rd_data;
  logic                   res_valid;
  fqsr_pkg::fqsr_result_t res;
  logic                   res_take;
  fqsr_pkg::fqsr_result_t out_res;

  fqsr_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  fqsr_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register loads when empty or when its transaction leaves this cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign found_position = out_res.found_position;
  assign occupancy      = out_res.occupancy;
  assign removed_value  = out_res.removed_value;

endmodule

>>> sv/fqsr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data updates only when a read is enabled and holds otherwise.
// No dependencies.
module fqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/fqsr_ctrl.sv
// Controller of the queue: ring pointers, count, direction flag and the op sequencer.
// Drives the entry RAM and hands one result record per transaction to the output stage.
// Depends on fqsr_pkg.
module fqsr_ctrl #(
  parameter int DEPTH      = fqsr_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = fqsr_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input transaction.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               op,
  input  logic signed [31:0]       value,
  // Entry RAM.
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [WORD_WIDTH-1:0]    wr_data,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [WORD_WIDTH-1:0]    rd_data,
  // Result handoff.
  output logic                     res_valid,
  output fqsr_pkg::fqsr_result_t   res,
  input  logic                     res_take
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  fqsr_pkg::fqsr_state_t state, state_next;

  logic [IW-1:0]          front, front_next;
  logic [CW-1:0]          count, count_next;
  logic                   rev, rev_next;
  logic [CW-1:0]          scan_pos, scan_pos_next;
  logic [WORD_WIDTH-1:0]  key, key_next;
  fqsr_pkg::fqsr_result_t res_next;

  logic                   accept;
  logic                   empty;
  logic                   full;
  logic [WORD_WIDTH-1:0]  word;
  logic [63:0]            value_ext;
  logic [63:0]            rd_ext;
  logic [CW-1:0]          scan_inc;
  logic                   scan_match;
  logic                   scan_last;
  logic [CW-1:0]          rd_pos;
  logic [CW-1:0]          rd_off;
  logic [CW:0]            rd_sum;
  logic [CW:0]            wr_sum;
  logic [IW-1:0]          front_inc;
  logic [IW-1:0]          front_dec;

  assign accept   = in_valid && (state == fqsr_pkg::ST_IDLE);
  assign in_stall = (state != fqsr_pkg::ST_IDLE);
  assign empty    = (count == '0);
  assign full     = (count == FULL_CNT);

  // Words are held in their low WORD_WIDTH bits, zero extended above 32.
  assign value_ext = {32'd0, value};
  assign word      = value_ext[WORD_WIDTH-1:0];
  assign rd_ext    = 64'(rd_data);

  // Search progress: rd_data holds the word at logical position scan_pos.
  assign scan_inc   = scan_pos + CW'(1);
  assign scan_match = (rd_data == key);
  assign scan_last  = (scan_inc == count);

  // Ring slot of a logical position; the sum stays below twice the depth.
  assign rd_pos = (state == fqsr_pkg::ST_SCAN) ? scan_inc : '0;
  assign rd_off = rev ? (count - CW'(1) - rd_pos) : rd_pos;
  assign rd_sum = {{(CW + 1 - IW){1'b0}}, front} + {1'b0, rd_off};
  assign rd_addr = (rd_sum >= DEPTH_W) ? IW'(rd_sum - DEPTH_W) : IW'(rd_sum);

  // Rear slot for an enqueue in forward order.
  assign wr_sum    = {{(CW + 1 - IW){1'b0}}, front} + {1'b0, count};
  assign front_inc = (front == LAST_IDX) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? LAST_IDX : front - IW'(1);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      fqsr_pkg::ST_IDLE: begin
        if (accept) begin
          if ((op == fqsr_pkg::OP_DEQUEUE) && !empty) begin
            state_next = fqsr_pkg::ST_READ;
          end else if ((op == fqsr_pkg::OP_SEARCH) && !empty) begin
            state_next = fqsr_pkg::ST_SCAN;
          end else begin
            state_next = fqsr_pkg::ST_EMIT;
          end
        end
      end
      fqsr_pkg::ST_READ: begin
        state_next = fqsr_pkg::ST_EMIT;
      end
      fqsr_pkg::ST_SCAN: begin
        if (scan_match || scan_last) begin
          state_next = fqsr_pkg::ST_EMIT;
        end
      end
      fqsr_pkg::ST_EMIT: begin
        if (res_take) begin
          state_next = fqsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fqsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM controls and result record.
  always_comb begin
    front_next    = front;
    count_next    = count;
    rev_next      = rev;
    scan_pos_next = scan_pos;
    key_next      = key;
    res_next      = res;
    wr_en         = 1'b0;
    wr_addr       = (wr_sum >= DEPTH_W) ? IW'(wr_sum - DEPTH_W) : IW'(wr_sum);
    wr_data       = word;
    rd_en         = 1'b0;
    case (state)
      fqsr_pkg::ST_IDLE: begin
        if (accept) begin
          res_next.status         = fqsr_pkg::STATUS_OK;
          res_next.found_position = '0;
          res_next.removed_value  = '0;
          case (op)
            fqsr_pkg::OP_ENQUEUE: begin
              if (full) begin
                res_next.status = fqsr_pkg::STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                if (rev) begin
                  front_next = front_dec;
                  wr_addr    = front_dec;
                end
              end
            end
            fqsr_pkg::OP_DEQUEUE: begin
              if (empty) begin
                res_next.status = fqsr_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - CW'(1);
                if (!rev) begin
                  front_next = front_inc;
                end
              end
            end
            fqsr_pkg::OP_COUNT: begin
              if (empty) begin
                res_next.status = fqsr_pkg::STATUS_EMPTY;
              end
            end
            fqsr_pkg::OP_SEARCH: begin
              if (empty) begin
                res_next.status = fqsr_pkg::STATUS_EMPTY;
              end else begin
                rd_en         = 1'b1;
                key_next      = word;
                scan_pos_next = '0;
              end
            end
            fqsr_pkg::OP_REVERSE: begin
              if (empty) begin
                res_next.status = fqsr_pkg::STATUS_EMPTY;
              end else if (count > CW'(1)) begin
                rev_next = !rev;
              end
            end
            default: begin
              // Unused codes leave the queue alone and report ok.
            end
          endcase
          res_next.occupancy = 5'(count_next);
        end
      end
      fqsr_pkg::ST_READ: begin
        res_next.removed_value = rd_ext[31:0];
      end
      fqsr_pkg::ST_SCAN: begin
        if (scan_match) begin
          res_next.found_position = 5'(scan_inc);
        end else if (!scan_last) begin
          rd_en         = 1'b1;
          scan_pos_next = scan_inc;
        end
      end
      default: begin
        // Result waits for the output stage.
      end
    endcase
  end

  assign res_valid = (state == fqsr_pkg::ST_EMIT);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqsr_pkg::ST_IDLE;
      front <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_pos <= scan_pos_next;
    key      <= key_next;
    res      <= res_next;
  end

endmodule

>>> tb/fqsr_checker.sv
// Scoreboard for the FIFO queue with search and reverse: predicts and compares results.
// Watches both channels of the block; depends on fqsr_pkg for codes and the result record.
// Reports its mismatch count and the number of results still awaited to the top.
module fqsr_checker #(
  parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [4:0]         found_position,
  input  logic [4:0]         occupancy,
  input  logic signed [31:0] removed_value,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the queue: ring of words, front slot, word count and direction.
  logic [31:0]  ring [DEPTH];
  int unsigned  head;
  int unsigned  held;
  bit           flipped;

  fqsr_pkg::fqsr_result_t pending_results [$];
  int           error_total = 0;

  // Ring slot of the word at logical position pos, where 0 is the front.
  function automatic int unsigned ring_slot(int unsigned pos);
    int unsigned off;
    off = flipped ? held - 1 - pos : pos;
    return (head + off) % DEPTH;
  endfunction

  // Applies one operation to the shadow queue and returns the result it should produce.
  function automatic fqsr_pkg::fqsr_result_t next_queue_result(logic [2:0] code,
                                                               logic [31:0] word);
    fqsr_pkg::fqsr_result_t r;
    bit           hit;
    r = '0;
    r.status = fqsr_pkg::STATUS_OK;
    hit = 1'b0;
    case (code)
      fqsr_pkg::OP_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = fqsr_pkg::STATUS_FULL;
        end else if (flipped) begin
          // With the order reversed, the rear sits just below the front slot.
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = word;
          held++;
        end else begin
          ring[(head + held) % DEPTH] = word;
          held++;
        end
      end
      fqsr_pkg::OP_DEQUEUE: begin
        if (held == 0) begin
          r.status = fqsr_pkg::STATUS_EMPTY;
        end else begin
          r.removed_value = ring[ring_slot(0)];
          if (!flipped) head = (head + 1) % DEPTH;
          held--;
        end
      end
      fqsr_pkg::OP_COUNT: begin
        if (held == 0) r.status = fqsr_pkg::STATUS_EMPTY;
      end
      fqsr_pkg::OP_SEARCH: begin
        if (held == 0) begin
          r.status = fqsr_pkg::STATUS_EMPTY;
        end else begin
          // The first match counted from the logical front wins.
          for (int unsigned i = 0; i < held; i++) begin
            if (!hit && ring[ring_slot(i)] == word) begin
              hit = 1'b1;
              r.found_position = 5'(i + 1);
            end
          end
        end
      end
      fqsr_pkg::OP_REVERSE: begin
        if (held == 0) r.status = fqsr_pkg::STATUS_EMPTY;
        else if (held > 1) flipped = !flipped;
      end
      default: begin
      end
    endcase
    r.occupancy = 5'(held);
    return r;
  endfunction

  // Record each accepted transaction, then match each accepted result against the oldest.
  always @(posedge clk) begin
    fqsr_pkg::fqsr_result_t want;
    if (rst) begin
      head = 0;
      held = 0;
      flipped = 1'b0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(next_queue_result(op, value));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          error_total++;
          $error("result with no transaction outstanding: status %0d occupancy %0d",
                 status, occupancy);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            error_total++;
            $error("status: expected %0d, actual %0d", want.status, status);
          end
          if (found_position !== want.found_position) begin
            error_total++;
            $error("found_position: expected %0d, actual %0d",
                   want.found_position, found_position);
          end
          if (occupancy !== want.occupancy) begin
            error_total++;
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
          end
          if (removed_value !== want.removed_value) begin
            error_total++;
            $error("removed_value: expected %h, actual %h",
                   want.removed_value, removed_value);
          end
        end
      end
    end
    mismatches  <= error_total;
    outstanding <= pending_results.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the testbench for fifo_queue_with_search_reverse_unit: clock, reset and stimulus.
// Instantiates the block and fqsr_checker beside it; depends on fqsr_pkg for codes.
// Gives the verdict from the checker's mismatch and outstanding counts.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Op codes the block ignores.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLD_OFF_AFTER = 200;
  localparam int HOLD_OFF_LEN   = 300;

  // Operation mix of a random stretch: mostly filling, mostly draining, or even.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         op;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [4:0]         found_position;
  logic [4:0]         occupancy;
  logic signed [31:0] removed_value;
  int                 mismatches;
  int                 outstanding;

  int                 sent_count = 0;
  bit                 hold_off_done = 1'b0;
  logic [31:0]        word_pool [8];

  fifo_queue_with_search_reverse_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .occupancy      (occupancy),
    .removed_value  (removed_value)
  );

  fqsr_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .occupancy      (occupancy),
    .removed_value  (removed_value),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #1_000_000;
    $display("FAIL fifo_queue_with_search_reverse_unit");
    $finish;
  end

  // Result receiver: runs of readiness and stalls, plus one long hold-off under load.
  initial begin
    int r;
    int ready_len;
    int stall_len;
    forever begin
      if (!hold_off_done && sent_count >= HOLD_OFF_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      ready_len = (r < 60) ? $urandom_range(1, 4) :
                  (r < 90) ? $urandom_range(5, 20) : $urandom_range(40, 100);
      out_stall <= 1'b0;
      repeat (ready_len) @(posedge clk);
      r = $urandom_range(0, 99);
      stall_len = (r < 80) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  // Offers one transaction, waits for its acceptance, then idles for a random gap.
  task automatic offer(input logic [2:0] code, input logic [31:0] word);
    int r;
    int gap;
    in_valid <= 1'b1;
    op       <= code;
    value    <= word;
    do @(posedge clk); while (in_stall);
    sent_count++;
    r = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Words mostly come from a small pool so that searches hit and duplicates occur.
  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 99) < 75) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Chooses an operation according to the current mix.
  function automatic logic [2:0] pick_op(mix_t mix);
    int enq_pct;
    int deq_pct;
    int r;
    case (mix)
      MIX_FILL:  begin enq_pct = 60; deq_pct = 10; end
      MIX_DRAIN: begin enq_pct = 15; deq_pct = 45; end
      default:   begin enq_pct = 35; deq_pct = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < enq_pct) return fqsr_pkg::OP_ENQUEUE;
    if (r < enq_pct + deq_pct) return fqsr_pkg::OP_DEQUEUE;
    r = $urandom_range(0, 99);
    if (r < 20) return fqsr_pkg::OP_COUNT;
    if (r < 60) return fqsr_pkg::OP_SEARCH;
    if (r < 95) return fqsr_pkg::OP_REVERSE;
    return 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
  endfunction

  // Stimulus: reset, directed corner cases, random stretches, then drain and verdict.
  initial begin
    mix_t        mix;
    logic [2:0]  code;
    int          counted;
    int          waited;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    op        <= fqsr_pkg::OP_ENQUEUE;
    value     <= '0;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7FFF_FFFF;
    word_pool[2] = 32'h0000_0000;
    word_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every operation but enqueue on an empty queue, the ignored codes included.
    offer(fqsr_pkg::OP_DEQUEUE, 32'h0000_0000);
    offer(fqsr_pkg::OP_COUNT, 32'h0000_0000);
    offer(fqsr_pkg::OP_SEARCH, 32'h0000_0000);
    offer(fqsr_pkg::OP_REVERSE, 32'h0000_0000);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) offer(3'(c), 32'hFFFF_FFFF);

    // One word: reverse has no visible effect, search finds it at the front.
    offer(fqsr_pkg::OP_ENQUEUE, 32'h8000_0000);
    offer(fqsr_pkg::OP_REVERSE, 32'h0000_0000);
    offer(fqsr_pkg::OP_SEARCH, 32'h8000_0000);
    offer(fqsr_pkg::OP_DEQUEUE, 32'h0000_0000);

    // Extreme words with a duplicate, searched before and after a reversal.
    offer(fqsr_pkg::OP_ENQUEUE, 32'h7FFF_FFFF);
    offer(fqsr_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
    offer(fqsr_pkg::OP_ENQUEUE, 32'h0000_0000);
    offer(fqsr_pkg::OP_ENQUEUE, 32'h7FFF_FFFF);
    offer(fqsr_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    offer(fqsr_pkg::OP_REVERSE, 32'h0000_0000);
    offer(fqsr_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    offer(fqsr_pkg::OP_SEARCH, 32'h1234_5678);
    offer(fqsr_pkg::OP_ENQUEUE, 32'h0000_0001);
    offer(fqsr_pkg::OP_DEQUEUE, 32'h0000_0000);
    offer(fqsr_pkg::OP_COUNT, 32'h0000_0000);
    offer(OP_UNUSED_FIRST, 32'h0000_0000);
    offer(fqsr_pkg::OP_REVERSE, 32'h0000_0000);

    // Random stretches that alternate between filling, draining and an even mix.
    counted = 0;
    mix = MIX_FILL;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        word_pool[$urandom_range(4, 7)] = $urandom;
      end
      code = pick_op(mix);
      offer(code, pick_word());
      if (code < OP_UNUSED_FIRST) counted++;
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then keep watching for stray ones.
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS fifo_queue_with_search_reverse_unit");
    end else begin
      $display("FAIL fifo_queue_with_search_reverse_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fqsr_pkg.sv
sv/fqsr_ram.sv
sv/fqsr_ctrl.sv
sv/fifo_queue_with_search_reverse_unit.sv
tb/fqsr_checker.sv
tb/tb_top.sv
